// ===== hw/rtl/cld_pkg.sv =====
// ----------------------------------------------------------------------------
// cld_pkg: shared types for the capacity-limited dispatcher
// Command/result word layouts, item kinds and entry phases.
// ----------------------------------------------------------------------------
`default_nettype none
package cld_pkg;

    localparam int unsigned MAX_OPS = 16;
    localparam int unsigned TIME_W  = 32;

    typedef enum logic [1:0] {
        KIND_LOAD     = 2'd0,
        KIND_SCHEDULE = 2'd1,
        KIND_FINISH   = 2'd2,
        KIND_RESTART  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_PENDING  = 2'd0,
        PH_RUN_FREE = 2'd1,
        PH_RUN_CAP  = 2'd2,
        PH_DONE     = 2'd3
    } phase_t;

    localparam logic [1:0] CFG_INIT_CAP  = 2'd0;
    localparam logic [1:0] CFG_ORDER     = 2'd1;
    localparam logic [1:0] CFG_OP_COUNT  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        entry_index;
        logic [15:0]       duration;
        logic [15:0]       importance;
        logic [15:0]       prereq_mask;
        logic [TIME_W-1:0] now;
    } cmd_word_t;

    typedef struct packed {
        logic              dispatched;
        logic [3:0]        op_index;
        logic [TIME_W-1:0] finish_time;
        logic              takes_capacity;
        logic [4:0]        finished_count;
        logic [7:0]        capacity_left;
        logic              last;
    } res_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cld_pick.sv =====
// ----------------------------------------------------------------------------
// cld_pick: shared compare unit
// Keeps the best candidate seen so far over a scan of the table.
// ----------------------------------------------------------------------------
`default_nettype none
module cld_pick
    import cld_pkg::*;
#(
    parameter int unsigned IDX_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             offer,
    input  wire logic             by_importance,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic [15:0]      importance,
    output logic                  found,
    output logic [IDX_W-1:0]      best_idx
);
    logic        found_reg;
    logic [IDX_W-1:0] best_reg;
    logic [15:0] best_imp_reg;
    logic        take;

    // scan runs in ascending index, so strict > keeps ties at lower index
    assign take = offer && (!found_reg || (by_importance && importance > best_imp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !clear)
        begin
            best_reg     <= idx;
            best_imp_reg <= importance;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/capacity_limited_priority_dispatcher.sv =====
// ----------------------------------------------------------------------------
// capacity_limited_priority_dispatcher: list scheduler with a capacity limit
// Operation table, sequencer and one shared best-candidate compare unit.
// ----------------------------------------------------------------------------
// Usage: a command word is taken when start is high and busy is low; busy then
// stays high until the last result has been shown. Results appear one per
// strobe cycle and cannot be stalled, so the receiver must take every strobe.
// A load gives no result. Restart clears all phases together, then strobes
// its status word from the status state. Finish sweeps all 16 entries, one a
// cycle, then shows its status word. Schedule sweeps once for free operations
// (first time after reset or restart only), then for every dispatch sweeps the
// table once to pick the best candidate and issues it; a candidate test checks
// its prerequisite mask against a done vector decoded from the phase flops.
// Each dispatch word waits in a hold register so the final word can carry last,
// so words trail their issue. A schedule gives at most 16 results; the sweeps
// through the table by the compare unit set its run time.
// ----------------------------------------------------------------------------
`default_nettype none
module capacity_limited_priority_dispatcher
    import cld_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire cmd_word_t cmd,
    output logic           strobe,
    output res_word_t      result,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    localparam int unsigned MAX_OPERATIONS = MAX_OPS;
    localparam int unsigned TIME_BITS      = TIME_W;
    localparam int unsigned IDX_W = $clog2(MAX_OPERATIONS);
    localparam int unsigned CNT_W = $clog2(MAX_OPERATIONS + 1);
    localparam int unsigned TBL   = (MAX_OPERATIONS < 16) ? MAX_OPERATIONS : 16;
    localparam logic [TIME_BITS:0] TIME_MAX = {1'b0, {TIME_BITS{1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE, S_CLASS, S_SCAN, S_ISSUE, S_FINISH, S_RESTART, S_STATUS
    } state_t;

    // entry table (small, read combinationally at the scan pointer and the picked index)
    logic [15:0]          dur_mem [MAX_OPERATIONS];
    logic [15:0]          imp_mem [MAX_OPERATIONS];
    logic [15:0]          pre_mem [MAX_OPERATIONS];
    logic [TIME_BITS-1:0] fin_mem [MAX_OPERATIONS];
    phase_t               phase_reg [MAX_OPERATIONS];

    state_t               state_reg;
    logic [7:0]           init_cap_reg, cap_reg;
    logic                 order_reg, classified_reg;
    logic [4:0]           opcnt_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [CNT_W-1:0]     ptr_reg;
    logic [4:0]           nres_reg, done_reg;
    logic                 strobe_reg;
    res_word_t            res_reg;
    res_word_t            hold_reg;       // newest word, not yet shown
    logic                 hold_valid_reg;
    res_word_t            hold_final;

    logic [CNT_W-1:0] n_act;
    logic [IDX_W-1:0] ptr_idx;
    logic [MAX_OPERATIONS-1:0] done_vec;
    logic [15:0]      mask_eff, done16;
    logic             cand, pick_found;
    logic [IDX_W-1:0] pick_idx;
    logic             scan_end;
    logic [TIME_BITS:0] sum;
    logic [TIME_BITS-1:0] fin_sat;

    assign n_act   = (opcnt_reg > 5'(MAX_OPERATIONS)) ? CNT_W'(MAX_OPERATIONS)
                                                    : CNT_W'(opcnt_reg);
    assign ptr_idx = ptr_reg[IDX_W-1:0];
    assign scan_end = (ptr_reg >= n_act);

    always_comb
    begin
        for (int k = 0; k < MAX_OPERATIONS; k++)
        begin
            done_vec[k] = (phase_reg[k] == PH_DONE);
        end
        done16 = '1;
        for (int k = 0; k < TBL; k++)
        begin
            done16[k] = done_vec[k] || (k >= int'(n_act));
        end
        mask_eff = pre_mem[ptr_idx] & ~done16;
        cand = !scan_end && phase_reg[ptr_idx] == PH_PENDING
               && dur_mem[ptr_idx] != 16'd0 && mask_eff == 16'd0;
    end

    // held word as it goes out when it is the final one
    always_comb
    begin
        hold_final      = hold_reg;
        hold_final.last = 1'b1;
    end

    cld_pick #(.IDX_W(IDX_W)) u_pick (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (state_reg != S_SCAN),
        .offer         (state_reg == S_SCAN && cand),
        .by_importance (order_reg),
        .idx           (ptr_idx),
        .importance    (imp_mem[ptr_idx]),
        .found         (pick_found),
        .best_idx      (pick_idx)
    );

    assign sum     = {1'b0, now_reg} + (TIME_BITS+1)'(dur_mem[pick_idx]);
    assign fin_sat = (sum > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : sum[TIME_BITS-1:0];

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign strobe    = strobe_reg;
    assign result    = res_reg;

    // table payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start && cmd.kind == KIND_LOAD
            && 32'(cmd.entry_index) < MAX_OPERATIONS)
        begin
            dur_mem[IDX_W'(cmd.entry_index)] <= cmd.duration;
            imp_mem[IDX_W'(cmd.entry_index)] <= cmd.importance;
            pre_mem[IDX_W'(cmd.entry_index)] <= cmd.prereq_mask;
        end
        if (state_reg == S_CLASS && !scan_end)
        begin
            fin_mem[ptr_idx] <= now_reg;
        end
        if (state_reg == S_ISSUE)
        begin
            fin_mem[pick_idx] <= fin_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            init_cap_reg   <= 8'd1;
            cap_reg        <= 8'd1;
            order_reg      <= 1'b0;
            opcnt_reg      <= 5'd0;
            classified_reg <= 1'b0;
            ptr_reg        <= '0;
            nres_reg       <= '0;
            done_reg       <= '0;
            strobe_reg     <= 1'b0;
            now_reg        <= '0;
            res_reg        <= '0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_OPERATIONS; k++)
            begin
                phase_reg[k] <= PH_PENDING;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    strobe_reg <= 1'b0;
                    if (cfg_valid)
                    begin
                        unique case (cfg_index)
                            CFG_INIT_CAP: init_cap_reg <= cfg_data;
                            CFG_ORDER:    order_reg    <= cfg_data[0];
                            CFG_OP_COUNT: opcnt_reg    <= cfg_data[4:0];
                            default:      ;
                        endcase
                    end
                    if (start)
                    begin
                        now_reg  <= cmd.now[TIME_BITS-1:0];
                        ptr_reg  <= '0;
                        nres_reg <= '0;
                        done_reg <= '0;
                        unique case (kind_t'(cmd.kind))
                            KIND_SCHEDULE:
                                state_reg <= classified_reg ? S_SCAN : S_CLASS;
                            KIND_FINISH:   state_reg <= S_FINISH;
                            KIND_RESTART:  state_reg <= S_RESTART;
                            default:       state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CLASS:
                begin
                    classified_reg <= 1'b1;
                    if (scan_end || nres_reg == 5'd16)
                    begin
                        strobe_reg <= 1'b0;
                        ptr_reg    <= '0;
                        state_reg  <= S_SCAN;
                    end
                    else
                    begin
                        if (phase_reg[ptr_idx] == PH_PENDING && dur_mem[ptr_idx] == 16'd0)
                        begin
                            phase_reg[ptr_idx] <= PH_RUN_FREE;
                            // show the previous word, keep the new one back
                            strobe_reg <= hold_valid_reg;
                            if (hold_valid_reg)
                            begin
                                res_reg <= hold_reg;
                            end
                            hold_reg   <= '{dispatched: 1'b1, op_index: 4'(ptr_idx),
                                            finish_time: TIME_W'(now_reg),
                                            takes_capacity: 1'b0, finished_count: 5'd0,
                                            capacity_left: cap_reg, last: 1'b0};
                            hold_valid_reg <= 1'b1;
                            nres_reg   <= nres_reg + 5'd1;
                        end
                        else
                        begin
                            strobe_reg <= 1'b0;
                        end
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    strobe_reg <= 1'b0;
                    if (cap_reg == 8'd0 || nres_reg == 5'd16)
                    begin
                        state_reg <= S_STATUS;
                    end
                    else if (scan_end)
                    begin
                        state_reg <= pick_found ? S_ISSUE : S_STATUS;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_ISSUE:
                begin
                    phase_reg[pick_idx] <= PH_RUN_CAP;
                    cap_reg    <= cap_reg - 8'd1;
                    strobe_reg <= hold_valid_reg;
                    if (hold_valid_reg)
                    begin
                        res_reg <= hold_reg;
                    end
                    hold_reg   <= '{dispatched: 1'b1, op_index: 4'(pick_idx),
                                    finish_time: TIME_W'(fin_sat), takes_capacity: 1'b1,
                                    finished_count: 5'd0, capacity_left: cap_reg - 8'd1,
                                    last: 1'b0};
                    hold_valid_reg <= 1'b1;
                    nres_reg   <= nres_reg + 5'd1;
                    ptr_reg    <= '0;
                    state_reg  <= S_SCAN;
                end
                S_FINISH:
                begin
                    strobe_reg <= 1'b0;
                    if (ptr_reg == CNT_W'(MAX_OPERATIONS))
                    begin
                        state_reg <= S_STATUS;
                    end
                    else
                    begin
                        if ((phase_reg[ptr_idx] == PH_RUN_FREE
                             || phase_reg[ptr_idx] == PH_RUN_CAP)
                            && fin_mem[ptr_idx] == now_reg)
                        begin
                            phase_reg[ptr_idx] <= PH_DONE;
                            done_reg <= done_reg + 5'd1;
                            if (phase_reg[ptr_idx] == PH_RUN_CAP && cap_reg != 8'hFF)
                            begin
                                cap_reg <= cap_reg + 8'd1;
                            end
                        end
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_RESTART:
                begin
                    strobe_reg <= 1'b0;
                    // finish times need no clear: only running entries compare them
                    for (int k = 0; k < MAX_OPERATIONS; k++)
                    begin
                        phase_reg[k] <= PH_PENDING;
                    end
                    cap_reg        <= init_cap_reg;
                    classified_reg <= 1'b0;
                    state_reg      <= S_STATUS;
                end
                S_STATUS:
                begin
                    // held dispatch word goes out as the final one; a status
                    // word only when the item emitted nothing
                    strobe_reg     <= 1'b1;
                    hold_valid_reg <= 1'b0;
                    if (hold_valid_reg)
                    begin
                        res_reg <= hold_final;
                    end
                    else
                    begin
                        res_reg <= '{dispatched: 1'b0, op_index: 4'd0,
                                     finish_time: '0, takes_capacity: 1'b0,
                                     finished_count: done_reg,
                                     capacity_left: cap_reg, last: 1'b1};
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= S_IDLE;
                end
            endcase
        end
    end

    property p_status_last;
        @(posedge clk) disable iff (!rst_n)
        (strobe && !result.dispatched) |-> result.last;
    endproperty
    assert property (p_status_last) else $error("status word without last");

    property p_idle_after_last;
        @(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |-> !busy;
    endproperty
    assert property (p_idle_after_last) else $error("busy after last word");

    property p_cap_use;
        @(posedge clk) disable iff (!rst_n)
        (strobe && result.takes_capacity) |-> result.dispatched;
    endproperty
    assert property (p_cap_use) else $error("capacity word not dispatched");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for capacity_limited_priority_dispatcher
// Drives command words through the start/busy port and register writes
// through the config channel. A built-in model of the operation table
// predicts every result word, and each strobe is compared with it field by
// field. A directed table comes first, then random phases of load, schedule,
// finish and restart commands under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import cld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_OPS     = 16;
    localparam int RESULT_CAP  = 16;
    localparam int SETTLE_CYC  = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    cmd_word_t cmd = '0;
    logic      strobe;
    res_word_t result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    capacity_limited_priority_dispatcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Dispatcher model: table contents, phases, capacity, registers
    // ------------------------------------------------------------------
    logic [15:0] op_dur  [NUM_OPS];
    logic [15:0] op_imp  [NUM_OPS];
    logic [15:0] op_pre  [NUM_OPS];
    phase_t      op_phase[NUM_OPS];
    logic [31:0] op_fin  [NUM_OPS];
    logic [7:0]  cap_free;
    bit          table_classified;
    logic [7:0]  reg_init_cap;
    bit          reg_by_importance;
    logic [4:0]  reg_op_count;

    res_word_t awaited_words[$];   // expected result words, oldest first
    int        error_count;

    function automatic void queue_word(logic disp, logic [3:0] idx, logic [31:0] fin,
                                       logic takes, logic [4:0] fcount);
        res_word_t w;
        w.dispatched     = disp;
        w.op_index       = idx;
        w.finish_time    = fin;
        w.takes_capacity = takes;
        w.finished_count = fcount;
        w.capacity_left  = cap_free;
        w.last           = 1'b0;
        awaited_words.push_back(w);
    endfunction

    function automatic void clear_table_state();
        for (int i = 0; i < NUM_OPS; i++)
        begin
            op_phase[i] = PH_PENDING;
            op_fin[i]   = '0;
        end
        cap_free         = reg_init_cap;
        table_classified = 1'b0;
    endfunction

    // entry i may start once every prerequisite inside the table is done
    function automatic bit prereqs_met(int i, int n);
        for (int k = 0; k < n; k++)
            if (op_pre[i][k] && op_phase[k] != PH_DONE)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void run_schedule(logic [31:0] now);
        int n;
        int emitted;
        int best;
        logic [32:0] sum;
        n = (reg_op_count > NUM_OPS) ? NUM_OPS : int'(reg_op_count);
        emitted = 0;
        // first schedule after restart: zero-duration entries run free, finishing at the current time
        if (!table_classified)
        begin
            table_classified = 1'b1;
            for (int i = 0; i < n; i++)
                if (op_phase[i] == PH_PENDING && op_dur[i] == 0)
                begin
                    op_phase[i] = PH_RUN_FREE;
                    op_fin[i]   = now;
                    queue_word(1'b1, i[3:0], now, 1'b0, 5'd0);
                    emitted++;
                end
        end
        while (cap_free > 0 && emitted < RESULT_CAP)
        begin
            best = -1;
            for (int i = 0; i < n; i++)
            begin
                if (op_phase[i] != PH_PENDING || op_dur[i] == 0 || !prereqs_met(i, n))
                    continue;
                if (best < 0 || (reg_by_importance && op_imp[i] > op_imp[best]))
                    best = i;
            end
            if (best < 0)
                break;
            cap_free--;
            op_phase[best] = PH_RUN_CAP;
            sum = {1'b0, now} + op_dur[best];
            op_fin[best] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            queue_word(1'b1, best[3:0], op_fin[best], 1'b1, 5'd0);
            emitted++;
        end
        if (emitted == 0)
            queue_word(1'b0, 4'd0, 32'd0, 1'b0, 5'd0);
    endfunction

    function automatic void run_finish(logic [31:0] now);
        int done_cnt;
        done_cnt = 0;
        for (int i = 0; i < NUM_OPS; i++)
            if ((op_phase[i] == PH_RUN_FREE || op_phase[i] == PH_RUN_CAP) && op_fin[i] == now)
            begin
                if (op_phase[i] == PH_RUN_CAP && cap_free < 8'd255)
                    cap_free++;
                op_phase[i] = PH_DONE;
                done_cnt++;
            end
        queue_word(1'b0, 4'd0, 32'd0, 1'b0, done_cnt[4:0]);
    endfunction

    // Update the model for one accepted command and queue its result words.
    function automatic void dispatch_model(cmd_word_t c);
        case (kind_t'(c.kind))
            KIND_LOAD:
            begin
                op_dur[c.entry_index] = c.duration;
                op_imp[c.entry_index] = c.importance;
                op_pre[c.entry_index] = c.prereq_mask;
                return;     // no result word
            end
            KIND_SCHEDULE: run_schedule(c.now);
            KIND_FINISH:   run_finish(c.now);
            default:
            begin
                clear_table_state();
                queue_word(1'b0, 4'd0, 32'd0, 1'b0, 5'd0);
            end
        endcase
        awaited_words[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: results cannot be stalled, so every strobe counts
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n && strobe)
        begin
            if (awaited_words.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected result word %h", result);
            end
            else
            begin
                want = awaited_words.pop_front();
                if (result.dispatched !== want.dispatched
                    || result.op_index !== want.op_index
                    || result.finish_time !== want.finish_time
                    || result.takes_capacity !== want.takes_capacity
                    || result.finished_count !== want.finished_count
                    || result.capacity_left !== want.capacity_left
                    || result.last !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: got disp=%b idx=%0d fin=%h cap_use=%b fcnt=%0d cap=%0d last=%b, expected disp=%b idx=%0d fin=%h cap_use=%b fcnt=%0d cap=%0d last=%b",
                                 result.dispatched, result.op_index, result.finish_time,
                                 result.takes_capacity, result.finished_count,
                                 result.capacity_left, result.last,
                                 want.dispatched, want.op_index, want.finish_time,
                                 want.takes_capacity, want.finished_count,
                                 want.capacity_left, want.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers: inputs move on the falling edge, handshakes seen on rising
    // ------------------------------------------------------------------
    function automatic cmd_word_t make_cmd(kind_t k, logic [3:0] idx, logic [15:0] dur,
                                           logic [15:0] imp, logic [15:0] pre,
                                           logic [31:0] now);
        cmd_word_t c;
        c.kind        = k;
        c.entry_index = idx;
        c.duration    = dur;
        c.importance  = imp;
        c.prereq_mask = pre;
        c.now         = now;
        return c;
    endfunction

    // Present one command word. start is left high on return so a back-to-back
    // word never lowers and raises it within the same step.
    task automatic send_word(cmd_word_t c, bit keep_literal, res_word_t literal);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            @(negedge clk) start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        cmd   = c;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        dispatch_model(c);
        if (keep_literal)
            awaited_words[$] = literal;     // typed-in single status word
    endtask

    task automatic send_cmd(cmd_word_t c);
        send_word(c, 1'b0, '0);
    endtask

    // Block is idle once nothing is owed and busy is low; loads leave no
    // result, so let the sequencer settle before touching regs.
    task automatic wait_idle();
        @(negedge clk) start = 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            CFG_INIT_CAP: reg_init_cap      = data;
            CFG_ORDER:    reg_by_importance = data[0];
            CFG_OP_COUNT: reg_op_count      = data[4:0];
            default: ;
        endcase
        @(negedge clk) cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        cmd_word_t c;
        bit        lit;     // expected word typed in below
        res_word_t r;
    } dir_row_t;

    function automatic res_word_t status_word(logic [4:0] fcount, logic [7:0] cap);
        res_word_t w;
        w = '0;
        w.finished_count = fcount;
        w.capacity_left  = cap;
        w.last           = 1'b1;
        return w;
    endfunction

    dir_row_t pre_rows[3];      // run with reset register values
    dir_row_t main_rows[22];    // run after registers are set

    function automatic void build_directed();
        // empty table (count 0): nothing to start, nothing to finish
        pre_rows[0] = '{make_cmd(KIND_SCHEDULE, 0, 0, 0, 0, 0), 1, status_word(0, 1)};
        pre_rows[1] = '{make_cmd(KIND_FINISH, 0, 0, 0, 0, 0), 1, status_word(0, 1)};
        pre_rows[2] = '{make_cmd(KIND_RESTART, 0, 0, 0, 0, 0), 1, status_word(0, 1)};
        // load all sixteen entries so no schedule ever touches an unwritten one
        for (int i = 0; i < NUM_OPS; i++)
            main_rows[i] = '{make_cmd(KIND_LOAD, i[3:0], 16'(i + 2), 16'(i * 100),
                                      16'h0, 32'h0), 0, '0};
        main_rows[0].c.duration     = 16'd0;        // operation-free
        main_rows[1].c.duration     = 16'hFFFF;     // saturates finish time
        main_rows[1].c.importance   = 16'hFFFF;
        main_rows[2].c.duration     = 16'd1;
        main_rows[3].c.prereq_mask  = 16'h0004;     // waits for entry 2
        main_rows[5].c.prereq_mask  = 16'hFFFF;     // waits on itself: never starts
        main_rows[15].c.importance  = 16'hFFFF;     // tie with entry 1
        main_rows[16] = '{make_cmd(KIND_SCHEDULE, 0, 0, 0, 0, 32'hFFFF_FFF0), 0, '0};
        main_rows[17] = '{make_cmd(KIND_FINISH, 0, 0, 0, 0, 32'hFFFF_FFF1), 0, '0};
        main_rows[18] = '{make_cmd(KIND_SCHEDULE, 0, 0, 0, 0, 32'hFFFF_FFF1), 0, '0};
        main_rows[19] = '{make_cmd(KIND_FINISH, 0, 0, 0, 0, 32'hFFFF_FFFF), 0, '0};
        // load after classification: phase kept, so done entry 2 stays done
        main_rows[20] = '{make_cmd(KIND_LOAD, 4'd2, 16'd0, 16'd7, 16'h0, 32'h0), 0, '0};
        main_rows[21] = '{make_cmd(KIND_RESTART, 0, 0, 0, 0, 0), 1, status_word(0, 8'd255)};
    endfunction

    // ------------------------------------------------------------------
    // Random phases
    // ------------------------------------------------------------------
    function automatic logic [15:0] rand_mask(int idx);
        // mostly earlier entries only, so chains resolve; sometimes anything
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($urandom) & 16'((1 << idx) - 1);
    endfunction

    task automatic random_load();
        int idx;
        logic [15:0] dur;
        idx = $urandom_range(0, NUM_OPS - 1);
        case ($urandom_range(0, 9))
            0: dur = 16'd0;
            1: dur = 16'($urandom);
            default: dur = 16'($urandom_range(1, 12));
        endcase
        send_cmd(make_cmd(KIND_LOAD, idx[3:0], dur, 16'($urandom), rand_mask(idx), 32'($urandom)));
    endtask

    // finish time of some running entry, or noise when none runs
    function automatic logic [31:0] pick_finish(logic [31:0] fallback);
        int live[$];
        for (int i = 0; i < NUM_OPS; i++)
            if (op_phase[i] == PH_RUN_FREE || op_phase[i] == PH_RUN_CAP)
                live.push_back(i);
        if (live.size() == 0 || $urandom_range(0, 9) == 0)
            return fallback;
        return op_fin[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    task automatic random_phase(int items);
        logic [31:0] clock_now;
        int pick;
        clock_now = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1000));
        send_cmd(make_cmd(KIND_RESTART, 0, 0, 0, 0, 32'($urandom)));
        for (int j = 0; j < items; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_cmd(make_cmd(KIND_SCHEDULE, 4'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), clock_now));
                clock_now += $urandom_range(0, 5);
            end
            else if (pick < 80)
                send_cmd(make_cmd(KIND_FINISH, 4'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), pick_finish(32'($urandom))));
            else if (pick < 95)
                random_load();
            else
                send_cmd(make_cmd(KIND_RESTART, 4'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 32'($urandom)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] cap_pick;
        logic [7:0] count_pick;
        error_count       = 0;
        reg_init_cap      = 8'd1;
        reg_by_importance = 1'b0;
        reg_op_count      = 5'd0;
        for (int i = 0; i < NUM_OPS; i++)
        begin
            op_dur[i] = '0;
            op_imp[i] = '0;
            op_pre[i] = '0;
        end
        clear_table_state();
        build_directed();

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        foreach (pre_rows[i])
            send_word(pre_rows[i].c, pre_rows[i].lit, pre_rows[i].r);
        wait_idle();
        write_reg(CFG_INIT_CAP, 8'd255);
        write_reg(CFG_ORDER, 8'd1);
        write_reg(CFG_OP_COUNT, 8'd16);
        foreach (main_rows[i])
            send_word(main_rows[i].c, main_rows[i].lit, main_rows[i].r);

        // random phases, register extremes in the first few
        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();    // sender holds off until every result is in
            case (ph)
                0: begin cap_pick = 8'd1;   count_pick = 8'd16; end
                1: begin cap_pick = 8'd0;   count_pick = 8'd31; end
                2: begin cap_pick = 8'd255; count_pick = 8'd0;  end
                3: begin cap_pick = 8'd3;   count_pick = 8'd17; end
                default:
                begin
                    cap_pick   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 5));
                    count_pick = 8'($urandom);
                end
            endcase
            write_reg(CFG_INIT_CAP, cap_pick);
            write_reg(CFG_ORDER, (ph == 2) ? 8'hFE : 8'($urandom));
            write_reg(CFG_OP_COUNT, count_pick);
            if (ph == 4)
                write_reg(2'd3, 8'($urandom));     // unmapped index, ignored
            random_phase(25);
        end

        wait_idle();
        if (error_count == 0 && awaited_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
